// ----- hw/rtl/bezier_point_evaluator_core_macros.svh -----
// Assertion macros shared by the Bezier point evaluator RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef BEZIER_POINT_EVALUATOR_CORE_MACROS_SVH
`define BEZIER_POINT_EVALUATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define BPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpe assertion failed");
`define BPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpe assertion failed");
`else
`define BPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/bpe_pkg.sv -----
// Package for the Bezier point evaluator: default widths, pipeline shape
// and the stage enable struct handed from the top level to the lanes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int T_FRAC_BITS_DEF   = 16;
    localparam int DEG_W             = 2;
    localparam int NUM_POINTS        = 4;
    localparam int NUM_LEVELS        = NUM_POINTS - 1;
    localparam int STAGES_PER_LEVEL  = 3;
    localparam int NUM_STAGES        = NUM_LEVELS * STAGES_PER_LEVEL;

    typedef struct packed {
        logic en_diff;
        logic en_mul;
        logic en_sum;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bezier_point_evaluator_core.sv -----
// Top level of the Bezier point evaluator; depends on bpe_pkg, bpe_level and the macro header.
// A result passes the stage registers of every interpolation level, then the output register;
// one item is accepted every cycle while the output drains.
// Each pipeline stage advances whenever the stage after it is empty or moving on.
// rst_n clears all valid flags asynchronously; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_point_evaluator_core_macros.svh"

module bezier_point_evaluator_core #(
    parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bpe_pkg::DEG_W-1:0]     curve_degree,
    input  wire logic signed [COORD_WIDTH-1:0] p0_x,
    input  wire logic signed [COORD_WIDTH-1:0] p0_y,
    input  wire logic signed [COORD_WIDTH-1:0] p1_x,
    input  wire logic signed [COORD_WIDTH-1:0] p1_y,
    input  wire logic signed [COORD_WIDTH-1:0] p2_x,
    input  wire logic signed [COORD_WIDTH-1:0] p2_y,
    input  wire logic signed [COORD_WIDTH-1:0] p3_x,
    input  wire logic signed [COORD_WIDTH-1:0] p3_y,
    input  wire logic [T_FRAC_BITS:0]          param_t,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y
);

    localparam int NSTG = bpe_pkg::NUM_STAGES;
    localparam int SPL  = bpe_pkg::STAGES_PER_LEVEL;
    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   stg_ready;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic signed [COORD_WIDTH-1:0] point_x_reg;
    logic signed [COORD_WIDTH-1:0] point_y_reg;

    logic [T_FRAC_BITS:0] t_sat;

    logic signed [COORD_WIDTH-1:0] l0_x [4];
    logic signed [COORD_WIDTH-1:0] l0_y [4];
    logic signed [COORD_WIDTH-1:0] l1_x [3];
    logic signed [COORD_WIDTH-1:0] l1_y [3];
    logic signed [COORD_WIDTH-1:0] l2_x [2];
    logic signed [COORD_WIDTH-1:0] l2_y [2];
    logic signed [COORD_WIDTH-1:0] l3_x [1];
    logic signed [COORD_WIDTH-1:0] l3_y [1];

    logic signed [COORD_WIDTH-1:0] l1_sel_x, l1_sel_y;
    logic signed [COORD_WIDTH-1:0] l2_sel_x, l2_sel_y;
    logic signed [COORD_WIDTH-1:0] l3_sel_x, l3_sel_y;
    logic [bpe_pkg::DEG_W-1:0]     l1_deg, l2_deg, l3_deg;
    logic [T_FRAC_BITS:0]          l1_t, l2_t, l3_t;

    bpe_pkg::lane_ctrl_t ctrl_l1, ctrl_l2, ctrl_l3;

    // Handshake chain: a stage may load when it is empty or its content moves on.
    always_comb
    begin
        stg_ready[NSTG] = !out_valid_reg || out_ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            stg_ready[k] = !vld_reg[k] || stg_ready[k+1];
        end
        vld_next[0] = stg_ready[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = stg_ready[k] ? vld_reg[k-1] : vld_reg[k];
        end
        out_valid_next = stg_ready[NSTG] ? vld_reg[NSTG-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ctrl_l1 = '{en_diff: stg_ready[0], en_mul: stg_ready[1], en_sum: stg_ready[2]};
    assign ctrl_l2 = '{en_diff: stg_ready[SPL], en_mul: stg_ready[SPL+1],
                       en_sum: stg_ready[SPL+2]};
    assign ctrl_l3 = '{en_diff: stg_ready[2*SPL], en_mul: stg_ready[2*SPL+1],
                       en_sum: stg_ready[2*SPL+2]};

    assign t_sat = (param_t > T_ONE) ? T_ONE : param_t;

    assign l0_x[0] = p0_x;
    assign l0_x[1] = p1_x;
    assign l0_x[2] = p2_x;
    assign l0_x[3] = p3_x;
    assign l0_y[0] = p0_y;
    assign l0_y[1] = p1_y;
    assign l0_y[2] = p2_y;
    assign l0_y[3] = p3_y;

    bpe_level #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS),
        .LEVEL      (1)
    ) u_level1 (
        .clk      (clk),
        .ctrl     (ctrl_l1),
        .in_x     (l0_x),
        .in_y     (l0_y),
        .in_sel_x (p0_x),
        .in_sel_y (p0_y),
        .in_deg   (curve_degree),
        .in_t     (t_sat),
        .out_x    (l1_x),
        .out_y    (l1_y),
        .out_sel_x(l1_sel_x),
        .out_sel_y(l1_sel_y),
        .out_deg  (l1_deg),
        .out_t    (l1_t)
    );

    bpe_level #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS),
        .LEVEL      (2)
    ) u_level2 (
        .clk      (clk),
        .ctrl     (ctrl_l2),
        .in_x     (l1_x),
        .in_y     (l1_y),
        .in_sel_x (l1_sel_x),
        .in_sel_y (l1_sel_y),
        .in_deg   (l1_deg),
        .in_t     (l1_t),
        .out_x    (l2_x),
        .out_y    (l2_y),
        .out_sel_x(l2_sel_x),
        .out_sel_y(l2_sel_y),
        .out_deg  (l2_deg),
        .out_t    (l2_t)
    );

    bpe_level #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS),
        .LEVEL      (3)
    ) u_level3 (
        .clk      (clk),
        .ctrl     (ctrl_l3),
        .in_x     (l2_x),
        .in_y     (l2_y),
        .in_sel_x (l2_sel_x),
        .in_sel_y (l2_sel_y),
        .in_deg   (l2_deg),
        .in_t     (l2_t),
        .out_x    (l3_x),
        .out_y    (l3_y),
        .out_sel_x(l3_sel_x),
        .out_sel_y(l3_sel_y),
        .out_deg  (l3_deg),
        .out_t    (l3_t)
    );

    // The merged point is held here until the item is taken.
    always_ff @(posedge clk)
    begin
        if (stg_ready[NSTG])
        begin
            point_x_reg <= l3_sel_x;
            point_y_reg <= l3_sel_y;
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;

    `BPE_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready, (&vld_reg) && out_valid && !out_ready)
    `BPE_ASSERT_NXT(a_accept_enters_pipe, clk, rst_n, in_valid && in_ready, vld_reg[0])
    `BPE_ASSERT_NXT(a_last_stage_drains, clk, rst_n, vld_reg[NSTG-1] && stg_ready[NSTG], out_valid)
    `BPE_ASSERT_NXT(a_empty_pipe_no_output, clk, rst_n, !(|vld_reg) && (!out_valid || out_ready), !out_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/bpe_lerp_lane.sv -----
// One interpolation lane: a + round((b - a) * t), over three register stages.
// Depends on bpe_pkg for the stage enable struct.
`timescale 1ns / 1ps
`default_nettype none

module bpe_lerp_lane #(
    parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire bpe_pkg::lane_ctrl_t           ctrl,
    input  wire logic signed [COORD_WIDTH-1:0] a,
    input  wire logic signed [COORD_WIDTH-1:0] b,
    input  wire logic        [T_FRAC_BITS:0]   t,
    output logic signed [COORD_WIDTH-1:0]      res
);

    localparam int PW = COORD_WIDTH + T_FRAC_BITS + 3;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_FRAC_BITS - 1);

    logic signed [COORD_WIDTH-1:0] a_reg;
    logic signed [COORD_WIDTH:0]   diff_reg;
    logic signed [COORD_WIDTH:0]   diff_next;
    logic        [T_FRAC_BITS:0]   t_reg;
    logic signed [COORD_WIDTH-1:0] base_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          prod_next;
    logic signed [PW-1:0]          sum_next;
    logic signed [COORD_WIDTH-1:0] res_reg;

    assign diff_next = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
    assign prod_next = diff_reg * $signed({1'b0, t_reg});
    assign sum_next  = $signed({{3{base_reg[COORD_WIDTH-1]}}, base_reg, {T_FRAC_BITS{1'b0}}})
                       + prod_reg + HALF;

    always_ff @(posedge clk)
    begin
        if (ctrl.en_diff)
        begin
            a_reg    <= a;
            diff_reg <= diff_next;
            t_reg    <= t;
        end
        if (ctrl.en_mul)
        begin
            base_reg <= a_reg;
            prod_reg <= prod_next;
        end
        if (ctrl.en_sum)
        begin
            res_reg <= sum_next[T_FRAC_BITS +: COORD_WIDTH];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bpe_level.sv -----
// One de Casteljau level: parallel x and y lanes between neighbouring points,
// plus the delayed side data. Depends on bpe_pkg and bpe_lerp_lane.
`timescale 1ns / 1ps
`default_nettype none

module bpe_level #(
    parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF,
    parameter int LEVEL       = 1,
    parameter int NUM_IN      = bpe_pkg::NUM_POINTS - LEVEL + 1
) (
    input  wire logic                              clk,
    input  wire bpe_pkg::lane_ctrl_t               ctrl,
    input  wire logic signed [COORD_WIDTH-1:0]     in_x [NUM_IN],
    input  wire logic signed [COORD_WIDTH-1:0]     in_y [NUM_IN],
    input  wire logic signed [COORD_WIDTH-1:0]     in_sel_x,
    input  wire logic signed [COORD_WIDTH-1:0]     in_sel_y,
    input  wire logic [bpe_pkg::DEG_W-1:0]         in_deg,
    input  wire logic [T_FRAC_BITS:0]              in_t,
    output logic signed [COORD_WIDTH-1:0]          out_x [NUM_IN-1],
    output logic signed [COORD_WIDTH-1:0]          out_y [NUM_IN-1],
    output logic signed [COORD_WIDTH-1:0]          out_sel_x,
    output logic signed [COORD_WIDTH-1:0]          out_sel_y,
    output logic [bpe_pkg::DEG_W-1:0]              out_deg,
    output logic [T_FRAC_BITS:0]                   out_t
);

    logic signed [COORD_WIDTH-1:0] sel_x_reg [bpe_pkg::STAGES_PER_LEVEL];
    logic signed [COORD_WIDTH-1:0] sel_y_reg [bpe_pkg::STAGES_PER_LEVEL];
    logic [bpe_pkg::DEG_W-1:0]     deg_reg   [bpe_pkg::STAGES_PER_LEVEL];
    logic [T_FRAC_BITS:0]          t_reg     [bpe_pkg::STAGES_PER_LEVEL];
    logic                          use_new;

    for (genvar i = 0; i < NUM_IN - 1; i++)
    begin : g_lane
        bpe_lerp_lane #(
            .COORD_WIDTH(COORD_WIDTH),
            .T_FRAC_BITS(T_FRAC_BITS)
        ) u_lane_x (
            .clk (clk),
            .ctrl(ctrl),
            .a   (in_x[i]),
            .b   (in_x[i+1]),
            .t   (in_t),
            .res (out_x[i])
        );
        bpe_lerp_lane #(
            .COORD_WIDTH(COORD_WIDTH),
            .T_FRAC_BITS(T_FRAC_BITS)
        ) u_lane_y (
            .clk (clk),
            .ctrl(ctrl),
            .a   (in_y[i]),
            .b   (in_y[i+1]),
            .t   (in_t),
            .res (out_y[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_diff)
        begin
            sel_x_reg[0] <= in_sel_x;
            sel_y_reg[0] <= in_sel_y;
            deg_reg[0]   <= in_deg;
            t_reg[0]     <= in_t;
        end
        if (ctrl.en_mul)
        begin
            sel_x_reg[1] <= sel_x_reg[0];
            sel_y_reg[1] <= sel_y_reg[0];
            deg_reg[1]   <= deg_reg[0];
            t_reg[1]     <= t_reg[0];
        end
        if (ctrl.en_sum)
        begin
            sel_x_reg[2] <= sel_x_reg[1];
            sel_y_reg[2] <= sel_y_reg[1];
            deg_reg[2]   <= deg_reg[1];
            t_reg[2]     <= t_reg[1];
        end
    end

    // A curve whose degree reaches this level takes the new leading point.
    assign use_new   = (deg_reg[2] >= bpe_pkg::DEG_W'(LEVEL));
    assign out_sel_x = use_new ? out_x[0] : sel_x_reg[2];
    assign out_sel_y = use_new ? out_y[0] : sel_y_reg[2];
    assign out_deg   = deg_reg[2];
    assign out_t     = t_reg[2];

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bezier_point_evaluator_core: directed and random curves.
// Results are predicted in the testbench and checked in order. Depends only on bpe_pkg and the RTL.

module testbench;

    localparam int  CW      = bpe_pkg::COORD_WIDTH_DEF;
    localparam int  TF      = bpe_pkg::T_FRAC_BITS_DEF;
    localparam int  DW      = bpe_pkg::DEG_W;
    localparam longint T_ONE  = longint'(1) << TF;
    localparam longint T_HALF = longint'(1) << (TF - 1);
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [TF:0]   T_FULL = {1'b1, {TF{1'b0}}};
    localparam logic [TF:0]   T_TOP  = {(TF+1){1'b1}};
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 20;

    typedef enum logic [DW-1:0] {
        DEG_POINT  = 2'd0,
        DEG_LINEAR = 2'd1,
        DEG_QUAD   = 2'd2,
        DEG_CUBIC  = 2'd3
    } degree_e;

    typedef struct packed {
        degree_e       degree;
        logic [CW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
        logic [TF:0]   t;
    } curve_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } point_t;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [DW-1:0] curve_degree = '0;
    logic [CW-1:0] p0_x = '0, p0_y = '0, p1_x = '0, p1_y = '0;
    logic [CW-1:0] p2_x = '0, p2_y = '0, p3_x = '0, p3_y = '0;
    logic [TF:0]   param_t = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [CW-1:0] point_x, point_y;

    point_t pending_points[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     hold_cycles = 0;
    bit     tx_idle_on  = 1'b1;
    bit     rx_idle_on  = 1'b1;

    bezier_point_evaluator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .curve_degree (curve_degree),
        .p0_x         (p0_x),
        .p0_y         (p0_y),
        .p1_x         (p1_x),
        .p1_y         (p1_y),
        .p2_x         (p2_x),
        .p2_y         (p2_y),
        .p3_x         (p3_x),
        .p3_y         (p3_y),
        .param_t      (param_t),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .point_x      (point_x),
        .point_y      (point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint interp(longint a, longint b, longint w);
        return (a * (T_ONE - w) + b * w + T_HALF) >>> TF;
    endfunction

    function automatic point_t eval_curve(curve_t c);
        longint xs[4];
        longint ys[4];
        longint w;
        int     deg;
        point_t p;
        w = (c.t > T_FULL) ? T_ONE : longint'(c.t);
        deg = int'(c.degree);
        xs[0] = $signed(c.x0); ys[0] = $signed(c.y0);
        xs[1] = $signed(c.x1); ys[1] = $signed(c.y1);
        xs[2] = $signed(c.x2); ys[2] = $signed(c.y2);
        xs[3] = $signed(c.x3); ys[3] = $signed(c.y3);
        for (int j = 1; j <= deg; j++)
        begin
            for (int i = 0; i + j <= deg; i++)
            begin
                xs[i] = interp(xs[i], xs[i+1], w);
                ys[i] = interp(ys[i], ys[i+1], w);
            end
        end
        p.x = xs[0][CW-1:0];
        p.y = ys[0][CW-1:0];
        return p;
    endfunction

    function automatic logic [CW-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2: return CW'($signed($urandom_range(0, 1023)) - 512);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic curve_t random_curve();
        curve_t c;
        c.degree = degree_e'($urandom_range(0, 3));
        c.x0 = random_coord(); c.y0 = random_coord();
        c.x1 = random_coord(); c.y1 = random_coord();
        c.x2 = random_coord(); c.y2 = random_coord();
        c.x3 = random_coord(); c.y3 = random_coord();
        case ($urandom_range(0, 19))
            0: c.t = '0;
            1: c.t = T_FULL;
            2, 3: c.t = (TF+1)'($urandom_range(int'(T_FULL) + 1, int'(T_TOP)));
            default: c.t = (TF+1)'($urandom_range(0, int'(T_FULL)));
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_curve(curve_t c);
        if (tx_idle_on && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        curve_degree <= c.degree;
        p0_x <= c.x0; p0_y <= c.y0;
        p1_x <= c.x1; p1_y <= c.y1;
        p2_x <= c.x2; p2_y <= c.y2;
        p3_x <= c.x3; p3_y <= c.y3;
        param_t      <= c.t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_points.push_back(eval_curve(c));
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        curve_t c;
        logic [TF:0] t_set[4];
        t_set = '{'0, T_FULL, T_FULL >> 1, T_TOP};
        foreach (t_set[k])
        begin
            for (int d = 0; d < 4; d++)
            begin
                c.degree = degree_e'(d);
                c.x0 = C_MAX; c.y0 = C_MIN; c.x1 = C_MIN; c.y1 = C_MAX;
                c.x2 = C_MAX; c.y2 = C_MIN; c.x3 = C_MIN; c.y3 = C_MAX;
                c.t = t_set[k];
                send_curve(c);
            end
        end
        c = random_curve();
        c.degree = DEG_CUBIC;
        c.t = T_FULL + 1'b1;
        send_curve(c);
        c.t = (TF+1)'(1);
        send_curve(c);
        c = '{DEG_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, T_FULL >> 1};
        send_curve(c);
        c = '{DEG_QUAD, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_FULL - 1'b1};
        send_curve(c);
        c = random_curve();
        c.degree = DEG_POINT;
        send_curve(c);
        c = '{DEG_LINEAR, CW'(-1), CW'(1), CW'(1), CW'(-1), '0, '0, '0, '0, T_FULL >> 1};
        send_curve(c);
        pause_until_drained();
    endtask

    task automatic test_random_traffic(int count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count) send_curve(random_curve());
    endtask

    task automatic test_streaming(int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count) send_curve(random_curve());
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        hold_cycles = 200;
        repeat (60) send_curve(random_curve());
    endtask

    task automatic test_drain_pause();
        repeat (5)
        begin
            repeat (20) send_curve(random_curve());
            pause_until_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_points.size() == 0)
                    report_mismatch("result with nothing pending", point_x, 'x);
                else
                begin
                    if (point_x !== pending_points[0].x)
                        report_mismatch("point_x", point_x, pending_points[0].x);
                    if (point_y !== pending_points[0].y)
                        report_mismatch("point_y", point_y, pending_points[0].y);
                    void'(pending_points.pop_front());
                end
            end
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
                out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 7);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(650);
        test_streaming(250);
        test_output_stall();
        test_drain_pause();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
